// File: rtl/btud_pkg.sv
// Package for the binary-tree ID discovery sequencer.
// Request and result structs, command and operation codes, default depths.
package btud_pkg;

    localparam int unsigned DEF_STACK_DEPTH = 64;
    localparam int unsigned DEF_TABLE_DEPTH = 256;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_QUERY = 2'd1;
    localparam logic [1:0] OP_MUTE  = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] RC_NONE    = 2'd0;
    localparam logic [1:0] RC_COLL    = 2'd1;
    localparam logic [1:0] RC_SINGLE  = 2'd2;
    localparam logic [1:0] RC_UNKNOWN = 2'd3;

    localparam logic [1:0] CMD_QUERY = 2'd0;
    localparam logic [1:0] CMD_MUTE  = 2'd1;
    localparam logic [1:0] CMD_DONE  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [47:0] range_lower;
        logic [47:0] range_upper;
        logic [1:0]  reply_code;
        logic [47:0] reply_id;
        logic        mute_ok;
    } req_t;

    typedef struct packed {
        logic [1:0]  command;
        logic [47:0] query_lower;
        logic [47:0] query_upper;
        logic [47:0] mute_id;
        logic [15:0] found_count;
        logic        fault;
    } res_t;

endpackage

// File: rtl/binary_tree_uid_discovery.sv
// Binary-tree discovery sequencer for 48-bit device IDs (top level).
// Uses btud_pkg and two btud_ram instances (range stack, found table).
//
//  channel  dir  handshake              payload
//  request  in   in_valid / in_stall    btud_pkg::req_t
//  result   out  out_valid / out_stall  btud_pkg::res_t
//  config   in   cfg_valid / cfg_ready  retry_limit, 4 bit
//
// Sequence per request: start, query replies and failed mutes go from EXEC to OUT;
// when a range is popped, the request passes through POP for the stack read first.
// Acknowledged mutes scan the found table, a read and a compare per entry,
// before OUT. A result stall holds OUT until the result is taken.
// Reset clears all control state; RAM contents are not cleared.
// A result waits in the output register; the next request is taken
// only once the result has been taken, one request at a time.
module binary_tree_uid_discovery #(
    parameter int unsigned STACK_DEPTH = btud_pkg::DEF_STACK_DEPTH,
    parameter int unsigned TABLE_DEPTH = btud_pkg::DEF_TABLE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  btud_pkg::req_t       in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output btud_pkg::res_t       out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [3:0]           cfg_data
);
    import btud_pkg::*;

    localparam int unsigned SAW = $clog2(STACK_DEPTH);
    localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int unsigned TCW = $clog2(TABLE_DEPTH + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_POP  = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]     st_reg, st_next;
    req_t           req_reg;
    logic [3:0]     limit_reg;
    logic [47:0]    lo_reg, hi_reg, pend_reg;
    logic [3:0]     retr_reg;
    logic [SCW-1:0] top_reg;
    logic [TCW-1:0] tcnt_reg;
    logic [TCW-1:0] idx_reg;
    logic [15:0]    tot_reg;
    logic           fault_reg;
    logic [1:0]     cmd_reg;

    logic           s_we;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [95:0]    s_rdata;
    logic           t_we;
    logic [TAW-1:0] t_raddr;
    logic [47:0]    t_rdata;

    logic [48:0]    sum;
    logic [47:0]    mid;
    logic           accept;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (st_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign sum       = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = sum[48:1];

    assign s_we    = (st_reg == S_EXEC) && (req_reg.operation == OP_QUERY)
                     && (req_reg.reply_code == RC_COLL) && (lo_reg < hi_reg)
                     && (top_reg < SCW'(STACK_DEPTH));
    assign s_waddr = top_reg[SAW-1:0];
    assign s_raddr = SAW'(top_reg - SCW'(1));
    assign t_we    = (st_reg == S_SCAN) && (idx_reg == tcnt_reg)
                     && (tcnt_reg < TCW'(TABLE_DEPTH));
    assign t_raddr = idx_reg[TAW-1:0];

    btud_ram #(.WIDTH(96), .DEPTH(STACK_DEPTH)) u_stack (
        .clk(clk), .we(s_we), .waddr(s_waddr),
        .wdata({mid + 48'd1, hi_reg}), .raddr(s_raddr), .rdata(s_rdata)
    );

    btud_ram #(.WIDTH(48), .DEPTH(TABLE_DEPTH)) u_table (
        .clk(clk), .we(t_we), .waddr(tcnt_reg[TAW-1:0]),
        .wdata(pend_reg), .raddr(t_raddr), .rdata(t_rdata)
    );

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (accept && in_data.operation != OP_NOP) st_next = S_EXEC;
            S_EXEC: st_next = S_OUT;
            S_POP:  st_next = S_OUT;
            S_SCAN: st_next = (idx_reg == tcnt_reg) ? S_OUT : S_CMP;
            S_CMP:  st_next = (t_rdata == pend_reg) ? S_OUT : S_SCAN;
            S_OUT:  if (!out_stall) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
        if (st_reg == S_EXEC)
        begin
            case (req_reg.operation)
                OP_QUERY:
                    if ((req_reg.reply_code == RC_COLL && lo_reg >= hi_reg)
                        || ((req_reg.reply_code == RC_NONE
                             || req_reg.reply_code == RC_UNKNOWN)
                            && retr_reg == 4'd0))
                        st_next = (top_reg == '0) ? S_OUT : S_POP;
                OP_MUTE:
                    if (req_reg.mute_ok) st_next = S_SCAN;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            req_reg   <= '0;
            limit_reg <= 4'd1;
            lo_reg    <= '0;
            hi_reg    <= '0;
            pend_reg  <= '0;
            retr_reg  <= '0;
            top_reg   <= '0;
            tcnt_reg  <= '0;
            idx_reg   <= '0;
            tot_reg   <= '0;
            fault_reg <= 1'b0;
            cmd_reg   <= CMD_QUERY;
        end
        else
        begin
            st_reg <= st_next;
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            unique case (st_reg)
                S_IDLE:
                    if (accept) req_reg <= in_data;
                S_EXEC:
                begin
                    cmd_reg <= CMD_QUERY;
                    idx_reg <= '0;
                    case (req_reg.operation)
                        OP_START:
                        begin
                            lo_reg    <= req_reg.range_lower;
                            hi_reg    <= req_reg.range_upper;
                            retr_reg  <= limit_reg;
                            top_reg   <= '0;
                            tot_reg   <= '0;
                            fault_reg <= 1'b0;
                        end
                        OP_QUERY:
                        begin
                            case (req_reg.reply_code)
                                RC_COLL:
                                    if (lo_reg >= hi_reg)
                                    begin
                                        fault_reg <= 1'b1;
                                        if (top_reg == '0) cmd_reg <= CMD_DONE;
                                    end
                                    else
                                    begin
                                        if (top_reg < SCW'(STACK_DEPTH))
                                            top_reg <= top_reg + SCW'(1);
                                        else
                                            fault_reg <= 1'b1;
                                        hi_reg   <= mid;
                                        retr_reg <= limit_reg;
                                    end
                                RC_SINGLE:
                                begin
                                    pend_reg <= req_reg.reply_id;
                                    cmd_reg  <= CMD_MUTE;
                                end
                                default:
                                    if (retr_reg != 4'd0)
                                        retr_reg <= retr_reg - 4'd1;
                                    else if (top_reg == '0)
                                        cmd_reg <= CMD_DONE;
                            endcase
                        end
                        default: ;
                    endcase
                end
                S_POP:
                begin
                    top_reg  <= top_reg - SCW'(1);
                    lo_reg   <= s_rdata[95:48];
                    hi_reg   <= s_rdata[47:0];
                    retr_reg <= limit_reg;
                end
                S_SCAN:
                    if (idx_reg == tcnt_reg)
                    begin
                        if (tcnt_reg < TCW'(TABLE_DEPTH))
                        begin
                            tcnt_reg <= tcnt_reg + TCW'(1);
                            if (tot_reg != 16'hFFFF) tot_reg <= tot_reg + 16'd1;
                        end
                        else
                        begin
                            fault_reg <= 1'b1;
                        end
                    end
                S_CMP:
                    idx_reg <= idx_reg + TCW'(1);
                S_OUT: ;
                default: ;
            endcase
        end
    end

    assign out_valid            = (st_reg == S_OUT);
    assign out_data.command     = cmd_reg;
    assign out_data.query_lower = (cmd_reg == CMD_DONE) ? '0 : lo_reg;
    assign out_data.query_upper = (cmd_reg == CMD_DONE) ? '0 : hi_reg;
    assign out_data.mute_id     = (cmd_reg == CMD_MUTE) ? pend_reg : '0;
    assign out_data.found_count = tot_reg;
    assign out_data.fault       = fault_reg;
endmodule

// File: rtl/btud_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module btud_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                           clk,
    input  logic                                           we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
    input  logic [WIDTH-1:0]                               wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
    output logic [WIDTH-1:0]                               rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: dv/binary_tree_uid_discovery_checker.sv
// Checker for the binary-tree ID discovery sequencer: watches the request, result and
// configuration channels, predicts each result and compares it field by field.
// Depends on btud_pkg.
`timescale 1ns / 100ps

module binary_tree_uid_discovery_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           in_stall,
    input  btud_pkg::req_t in_data,
    input  logic           out_valid,
    input  logic           out_stall,
    input  btud_pkg::res_t out_data,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [3:0]     cfg_data,
    output int             err_count,
    output int             pending,
    output logic [1:0]     last_cmd,
    output logic [47:0]    last_lo,
    output logic [47:0]    last_hi
);
    import btud_pkg::*;

    logic [3:0]  retry_limit;
    logic [47:0] cur_lo;
    logic [47:0] cur_hi;
    logic [3:0]  retries_left;
    logic [47:0] pending_id;
    logic [47:0] stack_lo [DEF_STACK_DEPTH];
    logic [47:0] stack_hi [DEF_STACK_DEPTH];
    int unsigned stack_top;
    logic [47:0] found_ids [DEF_TABLE_DEPTH];
    int unsigned table_count;
    logic [15:0] found_total;
    logic        fault_flag;
    res_t        expected_results [$];

    function automatic res_t make_result(logic [1:0] cmd);
        res_t r;
        r.command     = cmd;
        r.query_lower = (cmd == CMD_DONE) ? '0 : cur_lo;
        r.query_upper = (cmd == CMD_DONE) ? '0 : cur_hi;
        r.mute_id     = (cmd == CMD_MUTE) ? pending_id : '0;
        r.found_count = found_total;
        r.fault       = fault_flag;
        return r;
    endfunction

    function automatic res_t pop_range();
        if (stack_top == 0)
            return make_result(CMD_DONE);
        stack_top--;
        cur_lo = stack_lo[stack_top];
        cur_hi = stack_hi[stack_top];
        retries_left = retry_limit;
        return make_result(CMD_QUERY);
    endfunction

    function automatic bit id_known(logic [47:0] id);
        for (int i = 0; i < table_count; i++)
            if (found_ids[i] == id)
                return 1'b1;
        return 1'b0;
    endfunction

    // returns 0 when the request produces no result
    function automatic bit discovery_step(req_t r, output res_t res);
        logic [48:0] sum;
        logic [47:0] mid;
        case (r.operation)
            OP_START:
            begin
                cur_lo = r.range_lower;
                cur_hi = r.range_upper;
                retries_left = retry_limit;
                stack_top = 0;
                found_total = '0;
                fault_flag = 1'b0;
                res = make_result(CMD_QUERY);
            end
            OP_QUERY:
            begin
                if (r.reply_code == RC_COLL)
                begin
                    if (cur_lo >= cur_hi)
                    begin
                        fault_flag = 1'b1;
                        res = pop_range();
                    end
                    else
                    begin
                        sum = {1'b0, cur_lo} + {1'b0, cur_hi};
                        mid = sum[48:1];
                        if (stack_top < DEF_STACK_DEPTH)
                        begin
                            stack_lo[stack_top] = mid + 48'd1;
                            stack_hi[stack_top] = cur_hi;
                            stack_top++;
                        end
                        else
                            fault_flag = 1'b1;
                        cur_hi = mid;
                        retries_left = retry_limit;
                        res = make_result(CMD_QUERY);
                    end
                end
                else if (r.reply_code == RC_SINGLE)
                begin
                    pending_id = r.reply_id;
                    res = make_result(CMD_MUTE);
                end
                else if (retries_left > 0)
                begin
                    retries_left--;
                    res = make_result(CMD_QUERY);
                end
                else
                    res = pop_range();
            end
            OP_MUTE:
            begin
                if (r.mute_ok && !id_known(pending_id))
                begin
                    if (table_count < DEF_TABLE_DEPTH)
                    begin
                        found_ids[table_count] = pending_id;
                        table_count++;
                        if (found_total != 16'hFFFF)
                            found_total++;
                    end
                    else
                        fault_flag = 1'b1;
                end
                res = make_result(CMD_QUERY);
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_t exp_r;
        res_t new_r;
        if (!rst_n)
        begin
            retry_limit  = 4'd1;
            cur_lo       = '0;
            cur_hi       = '0;
            retries_left = '0;
            pending_id   = '0;
            stack_top    = 0;
            table_count  = 0;
            found_total  = '0;
            fault_flag   = 1'b0;
            expected_results.delete();
            err_count    = 0;
            pending      = 0;
            last_cmd     <= CMD_DONE;
            last_lo      <= '0;
            last_hi      <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                retry_limit = cfg_data;
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request outstanding: %p", out_data);
                    err_count++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (out_data.command !== exp_r.command)
                    begin
                        $error("command: expected %0d, got %0d", exp_r.command,
                               out_data.command);
                        err_count++;
                    end
                    if (out_data.query_lower !== exp_r.query_lower)
                    begin
                        $error("query_lower: expected %h, got %h", exp_r.query_lower,
                               out_data.query_lower);
                        err_count++;
                    end
                    if (out_data.query_upper !== exp_r.query_upper)
                    begin
                        $error("query_upper: expected %h, got %h", exp_r.query_upper,
                               out_data.query_upper);
                        err_count++;
                    end
                    if (out_data.mute_id !== exp_r.mute_id)
                    begin
                        $error("mute_id: expected %h, got %h", exp_r.mute_id,
                               out_data.mute_id);
                        err_count++;
                    end
                    if (out_data.found_count !== exp_r.found_count)
                    begin
                        $error("found_count: expected %0d, got %0d", exp_r.found_count,
                               out_data.found_count);
                        err_count++;
                    end
                    if (out_data.fault !== exp_r.fault)
                    begin
                        $error("fault: expected %0d, got %0d", exp_r.fault, out_data.fault);
                        err_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                if (discovery_step(in_data, new_r))
                begin
                    expected_results.push_back(new_r);
                    last_cmd <= new_r.command;
                    last_lo  <= new_r.query_lower;
                    last_hi  <= new_r.query_upper;
                end
            end
            pending = expected_results.size();
        end
    end

endmodule

// File: dv/binary_tree_uid_discovery_tb.sv
// Testbench top for binary_tree_uid_discovery: clock, reset, request and configuration
// stimulus, result-side stalls and the verdict. Depends on btud_pkg, the sequencer and the checker.
`timescale 1ns / 100ps

module binary_tree_uid_discovery_tb;
    import btud_pkg::*;

    localparam int NUM_REQUESTS = 1850;
    localparam logic [47:0] ID_MAX = 48'hFFFF_FFFF_FFFF;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    req_t        in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    res_t        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;
    int          err_count;
    int          pending;
    logic [1:0]  last_cmd;
    logic [47:0] last_lo;
    logic [47:0] last_hi;
    bit          quiet = 1'b0;
    int          stall_left = 0;
    int          sent = 0;

    always #10 clk = ~clk;

    binary_tree_uid_discovery u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    binary_tree_uid_discovery_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .err_count (err_count),
        .pending   (pending),
        .last_cmd  (last_cmd),
        .last_lo   (last_lo),
        .last_hi   (last_hi)
    );

    always @(posedge clk)
    begin
        if (quiet || !rst_n)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 99) < 15)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 12);
        end
        else
            out_stall <= 1'b0;
    end

    function automatic logic [47:0] rand_id();
        logic [63:0] v;
        v = {$urandom(), $urandom()};
        return v[47:0];
    endfunction

    function automatic req_t make_req(logic [1:0] op, logic [47:0] lo, logic [47:0] hi,
                                      logic [1:0] code, logic [47:0] id, logic ok);
        req_t r;
        r.operation   = op;
        r.range_lower = lo;
        r.range_upper = hi;
        r.reply_code  = code;
        r.reply_id    = id;
        r.mute_ok     = ok;
        return r;
    endfunction

    task automatic send_request(input req_t r);
        @(posedge clk);
        in_data  <= r;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        in_valid <= 1'b0;
        sent++;
        if (!quiet && $urandom_range(0, 99) < 30)
            repeat ($urandom_range(1, 13)) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_retry_limit(input logic [3:0] v);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        #100_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [47:0] lo;
        logic [47:0] hi;
        logic [47:0] id;
        logic [63:0] span;
        int          pick;
        int          session_len;
        int          session_no;
        int          dive_left;
        bit          ok;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed
        write_retry_limit(4'd0);
        send_request(make_req(OP_START, 48'd5, 48'd5, RC_NONE, '0, 1'b0));
        send_request(make_req(OP_QUERY, '0, '0, RC_COLL, '0, 1'b0));
        send_request(make_req(OP_START, 48'd10, 48'd3, RC_NONE, '0, 1'b0));
        send_request(make_req(OP_QUERY, '0, '0, RC_NONE, '0, 1'b0));
        write_retry_limit(4'd15);
        send_request(make_req(OP_START, '0, ID_MAX, RC_NONE, '0, 1'b0));
        send_request(make_req(OP_QUERY, ID_MAX, '0, RC_SINGLE, ID_MAX, 1'b0));
        send_request(make_req(OP_MUTE, '0, '0, RC_NONE, '0, 1'b1));
        send_request(make_req(OP_MUTE, '0, '0, RC_NONE, '0, 1'b1));
        send_request(make_req(OP_MUTE, '0, '0, RC_NONE, '0, 1'b0));
        send_request(make_req(OP_QUERY, '0, '0, RC_UNKNOWN, '0, 1'b0));
        send_request(make_req(OP_QUERY, '0, '0, RC_NONE, '0, 1'b0));
        send_request(make_req(OP_QUERY, '0, '0, RC_COLL, '0, 1'b0));
        send_request(make_req(OP_QUERY, '0, '0, RC_COLL, '0, 1'b0));
        send_request(make_req(OP_QUERY, '0, '0, RC_SINGLE, '0, 1'b0));
        send_request(make_req(OP_MUTE, ID_MAX, ID_MAX, RC_UNKNOWN, ID_MAX, 1'b1));
        send_request(make_req(OP_NOP, ID_MAX, ID_MAX, RC_UNKNOWN, ID_MAX, 1'b1));
        send_request(make_req(OP_MUTE, '0, '0, RC_NONE, '0, 1'b1));
        send_request(make_req(OP_QUERY, '0, '0, RC_SINGLE, 48'h0000_0000_0001, 1'b0));
        send_request(make_req(OP_QUERY, '0, '0, RC_NONE, '0, 1'b0));
        send_request(make_req(OP_START, ID_MAX, ID_MAX, RC_NONE, '0, 1'b0));
        send_request(make_req(OP_QUERY, '0, '0, RC_COLL, '0, 1'b0));
        write_retry_limit(4'd1);

        // random sessions
        session_len = 1000;
        session_no = 0;
        dive_left = 0;
        while (sent < NUM_REQUESTS)
        begin
            if (sent > NUM_REQUESTS - 200)
                quiet = 1'b1;
            if (last_cmd == CMD_DONE || session_len > 160)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    write_retry_limit(pick < 5 ? 4'd0 : pick < 10 ? 4'd15 : 4'($urandom));
                session_no++;
                session_len = 0;
                pick = $urandom_range(0, 99);
                if (session_no == 3 || session_no == 40)
                begin
                    lo = '0;
                    hi = ID_MAX;
                    dive_left = 70;
                end
                else if (pick < 60)
                begin
                    lo = rand_id();
                    hi = (lo > ID_MAX - 48'd300) ? ID_MAX : lo + 48'($urandom_range(0, 300));
                end
                else if (pick < 88)
                begin
                    lo = rand_id();
                    hi = rand_id();
                end
                else
                begin
                    lo = '0;
                    hi = ID_MAX;
                end
                send_request(make_req(OP_START, lo, hi, 2'($urandom), rand_id(), 1'($urandom)));
                continue;
            end
            session_len++;
            if (dive_left > 0)
            begin
                dive_left--;
                send_request(make_req(OP_QUERY, rand_id(), rand_id(), RC_COLL, rand_id(),
                                      1'($urandom)));
                continue;
            end
            if ($urandom_range(0, 99) < 5)
            begin
                send_request(make_req(2'($urandom), rand_id(), rand_id(), 2'($urandom),
                                      rand_id(), 1'($urandom)));
                continue;
            end
            if (last_cmd == CMD_MUTE)
            begin
                ok = ($urandom_range(0, 99) < 85);
                send_request(make_req(OP_MUTE, rand_id(), rand_id(), 2'($urandom),
                                      rand_id(), ok));
                continue;
            end
            pick = $urandom_range(0, 9);
            if (last_lo <= last_hi)
            begin
                span = 64'(last_hi - last_lo) + 64'd1;
                id = last_lo + 48'({$urandom(), $urandom()} % span);
            end
            else
                id = rand_id();
            if (last_lo == last_hi)
                send_request(make_req(OP_QUERY, rand_id(), rand_id(),
                                      pick < 7 ? RC_SINGLE : pick < 8 ? RC_COLL : RC_NONE,
                                      id, 1'($urandom)));
            else
                send_request(make_req(OP_QUERY, rand_id(), rand_id(),
                                      pick < 3 ? RC_COLL : pick < 6 ? RC_SINGLE :
                                      pick < 9 ? RC_NONE : RC_UNKNOWN,
                                      id, 1'($urandom)));
        end

        while (pending != 0) @(negedge clk);
        repeat (300) @(posedge clk);
        if (err_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: sim.f
rtl/btud_pkg.sv
rtl/btud_ram.sv
rtl/binary_tree_uid_discovery.sv
dv/binary_tree_uid_discovery_checker.sv
dv/binary_tree_uid_discovery_tb.sv
